@@ hw/rtl/mwpo_pkg.sv @@
// Shared types, constants and the sine table generator for the multi-waveform oscillator.
package mwpo_pkg;

    // Default sizes of the datapath.
    localparam int PHASE_BITS_DEF      = 24;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    // Fixed widths of the stream and configuration fields.
    localparam int STEP_W      = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Quarter turn scaled to Q30.
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WAVEFORM    = 1'b0,
        REG_START_PHASE = 1'b1
    } reg_index_e;

    // Waveform codes.
    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SQUARE = 2'd1,
        WAVE_SAW    = 2'd2,
        WAVE_SAWSIN = 2'd3
    } wave_e;

    // How the back end forms the sample of one item.
    typedef enum logic [1:0] {
        SEL_TABLE     = 2'd0,
        SEL_SQUARE    = 2'd1,
        SEL_RAMP_DOWN = 2'd2,
        SEL_RAMP_UP   = 2'd3
    } sel_e;

    // Control word handed from the front through the queue to the back.
    typedef struct packed {
        sel_e sel;
        logic negate;
    } ctrl_t;

    // Quarter-wave sine entry k, evaluated at elaboration time only.
    // An eight-term Taylor series in Q30 with truncating divisions, then
    // rounded to full scale and clamped.
    function automatic longint quarter_sine(input longint unsigned k, input int tb,
                                            input int sb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned full_pos;
        longint          sum;
        longint          v;
        x        = (PI_HALF_Q30 * k) >> tb;
        x2       = (x * x) >> 30;
        term     = x;
        sum      = longint'(x);
        full_pos = (64'd1 << (sb - 1)) - 64'd1;
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x2) >> 30;
            unique case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                default: term = term / 210;
            endcase
            if (n[0])
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (sum * longint'(full_pos) + (64'sd1 <<< 29)) >>> 30;
        if (v > longint'(full_pos))
        begin
            v = longint'(full_pos);
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/mwpo_front.sv @@
// Front end: configuration registers, phase accumulator and per-item classification.
module mwpo_front #(
    parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mwpo_pkg::STEP_W-1:0]         s_tdata,
    input  logic                                s_tuser,
    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [mwpo_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mwpo_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Queue write side.
    input  logic                                q_full,
    output logic                                q_push,
    output mwpo_pkg::ctrl_t                     q_ctrl,
    output logic [SINE_TABLE_BITS:0]            q_tab_idx,
    output logic [SAMPLE_BITS-1:0]              q_ramp
);

    localparam int REST_BITS = PHASE_BITS - 2;
    localparam int QTR_LEN   = 1 << SINE_TABLE_BITS;

    mwpo_pkg::wave_e          waveform_reg;
    logic [PHASE_BITS-1:0]    acc_reg;
    logic [PHASE_BITS-1:0]    acc_next;
    logic [PHASE_BITS-1:0]    step;
    logic [REST_BITS-1:0]     rest;
    logic [1:0]               quad;
    logic [SINE_TABLE_BITS-1:0] tab_pos;
    logic                     above_half;
    logic                     accept;

    // An item is taken whenever the queue has room.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    // New phase: optional restart, then add the step, wrapping at one turn.
    assign step     = PHASE_BITS'(s_tdata);
    assign acc_next = (s_tuser ? '0 : acc_reg) + step;

    assign quad       = acc_next[PHASE_BITS-1 -: 2];
    assign rest       = acc_next[REST_BITS-1:0];
    assign above_half = acc_next[PHASE_BITS-1] && (acc_next[PHASE_BITS-2:0] != '0);

    // Table position within a quarter, and the phase rescaled to sample width.
    if (REST_BITS >= SINE_TABLE_BITS)
    begin : g_tab_shr
        assign tab_pos = SINE_TABLE_BITS'(rest >> (REST_BITS - SINE_TABLE_BITS));
    end
    else
    begin : g_tab_shl
        assign tab_pos = SINE_TABLE_BITS'(rest) << (SINE_TABLE_BITS - REST_BITS);
    end

    if (PHASE_BITS >= SAMPLE_BITS)
    begin : g_ramp_shr
        assign q_ramp = SAMPLE_BITS'(acc_next >> (PHASE_BITS - SAMPLE_BITS));
    end
    else
    begin : g_ramp_shl
        assign q_ramp = SAMPLE_BITS'(acc_next) << (SAMPLE_BITS - PHASE_BITS);
    end

    // Odd quadrants read the table mirrored.
    assign q_tab_idx = quad[0] ? ((SINE_TABLE_BITS + 1)'(QTR_LEN) - {1'b0, tab_pos})
                               : {1'b0, tab_pos};

    // Classify the item by waveform and position within the turn.
    always_comb
    begin
        q_ctrl.sel    = mwpo_pkg::SEL_TABLE;
        q_ctrl.negate = 1'b0;
        unique case (waveform_reg)
            mwpo_pkg::WAVE_SINE:
            begin
                q_ctrl.sel    = mwpo_pkg::SEL_TABLE;
                q_ctrl.negate = quad[1];
            end
            mwpo_pkg::WAVE_SQUARE:
            begin
                q_ctrl.sel    = mwpo_pkg::SEL_SQUARE;
                q_ctrl.negate = !acc_next[PHASE_BITS-1];
            end
            mwpo_pkg::WAVE_SAW:
            begin
                q_ctrl.sel    = mwpo_pkg::SEL_RAMP_DOWN;
                q_ctrl.negate = 1'b0;
            end
            mwpo_pkg::WAVE_SAWSIN:
            begin
                if (above_half)
                begin
                    q_ctrl.sel    = mwpo_pkg::SEL_TABLE;
                    q_ctrl.negate = !quad[1];
                end
                else
                begin
                    q_ctrl.sel    = mwpo_pkg::SEL_RAMP_UP;
                    q_ctrl.negate = 1'b0;
                end
            end
        endcase
    end

    // Configuration registers and the phase accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= mwpo_pkg::WAVE_SINE;
            acc_reg      <= '0;
        end
        else
        begin
            priority if (cfg_we && cfg_index == mwpo_pkg::REG_WAVEFORM)
            begin
                waveform_reg <= mwpo_pkg::wave_e'(cfg_data[1:0]);
            end
            else if (cfg_we && cfg_index == mwpo_pkg::REG_START_PHASE)
            begin
                acc_reg <= PHASE_BITS'(cfg_data);
            end
            else if (accept)
            begin
                acc_reg <= acc_next;
            end
            else
            begin
                acc_reg <= acc_reg;
            end
        end
    end

endmodule

@@ hw/rtl/mwpo_queue.sv @@
// Short first-in first-out queue between the front and back ends.
module mwpo_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mwpo_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Pointer advance with wrap at the queue depth.
    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill count follows a lone push.
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

    // No write into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    // No read from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue read while empty");

endmodule

@@ hw/rtl/mwpo_back.sv @@
// Back end: sine table read, waveform forming, saturation and output register.
module mwpo_back #(
    parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Queue read side.
    input  logic                       q_valid,
    output logic                       q_pop,
    input  mwpo_pkg::ctrl_t            q_ctrl,
    input  logic [SINE_TABLE_BITS:0]   q_tab_idx,
    input  logic [SAMPLE_BITS-1:0]     q_ramp,
    // Result stream.
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [SAMPLE_BITS-1:0]     out_sample
);

    localparam int TAB_DEPTH = (1 << SINE_TABLE_BITS) + 1;
    localparam int VAL_W     = SAMPLE_BITS + 2;
    localparam logic signed [VAL_W-1:0] HALF     = VAL_W'(1) << (SAMPLE_BITS - 1);
    localparam logic signed [VAL_W-1:0] FULL_POS = HALF - VAL_W'(1);
    localparam logic signed [VAL_W-1:0] FULL_NEG = -HALF;

    logic [SAMPLE_BITS-2:0]    sine_rom [TAB_DEPTH];
    logic [SAMPLE_BITS-2:0]    tab_reg;
    mwpo_pkg::ctrl_t           s1_ctrl_reg;
    logic [SAMPLE_BITS-1:0]    s1_ramp_reg;
    logic                      s1_valid_reg;
    logic                      out_valid_reg;
    logic [SAMPLE_BITS-1:0]    sample_reg;
    logic [SAMPLE_BITS-1:0]    sample_next;
    logic signed [VAL_W-1:0]   tab_val;
    logic signed [VAL_W-1:0]   ramp_val;
    logic signed [VAL_W-1:0]   val;
    logic                      s1_move;
    logic                      s1_load;

    // Quarter-wave table contents, fixed at elaboration.
    for (genvar k = 0; k < TAB_DEPTH; k++)
    begin : g_rom
        assign sine_rom[k] =
            (SAMPLE_BITS - 1)'(mwpo_pkg::quarter_sine(64'(k), SINE_TABLE_BITS, SAMPLE_BITS));
    end

    // Stage handoff: the output register frees when its sample is taken.
    assign s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_load = !s1_valid_reg || s1_move;
    assign q_pop   = q_valid && s1_load;

    assign out_valid  = out_valid_reg;
    assign out_sample = sample_reg;

    // Form the signed value, then saturate to the sample range.
    assign tab_val  = VAL_W'(tab_reg);
    assign ramp_val = VAL_W'(s1_ramp_reg);

    always_comb
    begin
        unique case (s1_ctrl_reg.sel)
            mwpo_pkg::SEL_TABLE:     val = s1_ctrl_reg.negate ? -tab_val : tab_val;
            mwpo_pkg::SEL_SQUARE:    val = s1_ctrl_reg.negate ? FULL_NEG : FULL_POS;
            mwpo_pkg::SEL_RAMP_DOWN: val = HALF - ramp_val;
            mwpo_pkg::SEL_RAMP_UP:   val = ramp_val - HALF;
        endcase
        priority if (val > FULL_POS)
        begin
            sample_next = FULL_POS[SAMPLE_BITS-1:0];
        end
        else if (val < FULL_NEG)
        begin
            sample_next = FULL_NEG[SAMPLE_BITS-1:0];
        end
        else
        begin
            sample_next = val[SAMPLE_BITS-1:0];
        end
    end

    // Valid flags and control word of the table stage, and the output register flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_ctrl_reg   <= '{sel: mwpo_pkg::SEL_TABLE, negate: 1'b0};
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= q_valid;
            end
            if (q_pop)
            begin
                s1_ctrl_reg <= q_ctrl;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Table read and payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            tab_reg     <= sine_rom[q_tab_idx];
            s1_ramp_reg <= q_ramp;
        end
        if (s1_move)
        begin
            sample_reg <= sample_next;
        end
    end

    // A table-stage item waits while the output register is held.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |=> s1_valid_reg)
        else $error("table stage item lost during output stall");

endmodule

@@ hw/rtl/multi_waveform_phase_oscillator.sv @@
// Top level of the multi-waveform phase oscillator: front, queue and back end.
// Path: a phase step passes the queue, the table stage register and the output register.
// Throughput: one item per clock while m_tready does not stall the output; the front
// accumulator add and the back-end table read and output register each handle one item
// per cycle, and a four-entry queue lets either side stall on its own.
// Reset: phase accumulator to zero, waveform to sine, queue and back end empty.
module multi_waveform_phase_oscillator #(
    parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mwpo_pkg::STEP_W-1:0]           s_tdata,   // [23:0] phase_step
    input  logic                                  s_tuser,   // [0] restart
    // Result stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,  // [SAMPLE_BITS-1:0] sample
    // Configuration writes.
    input  logic                                  cfg_we,
    input  logic [mwpo_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mwpo_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CTRL_W = $bits(mwpo_pkg::ctrl_t);
    localparam int IDX_W  = SINE_TABLE_BITS + 1;
    localparam int Q_W    = CTRL_W + IDX_W + SAMPLE_BITS;

    logic                    q_full;
    logic                    q_push;
    logic                    q_pop;
    logic                    q_not_empty;
    mwpo_pkg::ctrl_t         f_ctrl;
    logic [IDX_W-1:0]        f_tab_idx;
    logic [SAMPLE_BITS-1:0]  f_ramp;
    logic [Q_W-1:0]          q_wdata;
    logic [Q_W-1:0]          q_rdata;
    mwpo_pkg::ctrl_t         b_ctrl;
    logic [IDX_W-1:0]        b_tab_idx;
    logic [SAMPLE_BITS-1:0]  b_ramp;
    logic [SAMPLE_BITS-1:0]  sample;

    mwpo_front #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_ctrl    (f_ctrl),
        .q_tab_idx (f_tab_idx),
        .q_ramp    (f_ramp)
    );

    // Queue word: ramp in the low bits, then table index, then control.
    assign q_wdata = {f_ctrl, f_tab_idx, f_ramp};
    assign {b_ctrl, b_tab_idx, b_ramp} = q_rdata;

    mwpo_queue #(
        .WIDTH (Q_W),
        .DEPTH (mwpo_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .not_empty (q_not_empty)
    );

    mwpo_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_pop      (q_pop),
        .q_ctrl     (b_ctrl),
        .q_tab_idx  (b_tab_idx),
        .q_ramp     (b_ramp),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (sample)
    );

    // Sample in the low bits, zero fill up to a whole byte.
    assign m_tdata = OUT_W'(sample);

endmodule
